/* src/oal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered array list package
// Shared sizes, operation, status and state codes, transaction and memory structs.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_SEARCH,
        S_READ
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [31:0] item_value;
        logic [7:0]  position;
    } t_req;

    typedef struct packed {
        logic [31:0] read_value;
        logic        found;
        logic [4:0]  entry_count;
        t_status     status;
    } t_rsp;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } t_ram_req;

endpackage
`default_nettype wire

/* src/ordered_array_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered array list
// A fixed-capacity ordered list of words held in a synchronous memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. It carries an
// operation (insert, delete, search or read), a word and a position. Exactly
// one result follows: o_done is high for one cycle with o_rsp valid, and the
// receiver must take it then, since it cannot stall the block.
// The result appears in the first cycle in which busy is low again, so a new
// transaction may be started in that same cycle. With n entries, the position
// is clamped to n for an insert and to n - 1 for a delete or read. An insert
// into a full list, or a delete, search or read on an empty list, is answered
// without the block going busy. Insert, delete and search walk the memory one
// entry per cycle through its single read port and single write port.
// Reset empties the list at once; the entries themselves are not cleared.
// ----------------------------------------------------------------------------
module ordered_array_list (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire oal_pkg::t_req   i_req,
    output logic                 busy,
    output logic                 o_done,
    output oal_pkg::t_rsp        o_rsp
);
    import oal_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_wa, n_wa;
    logic                  r_pend, n_pend;
    logic                  r_found, n_found;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    t_ram_req              ram_req;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [CNT_W-1:0]      pos_ins;
    logic [CNT_W-1:0]      pos_last;
    logic [CNT_W-1:0]      pos_rd;
    logic [CNT_W-1:0]      cur_dec;
    logic [CNT_W-1:0]      cur_inc;
    logic                  hit;

    function automatic t_rsp make_rsp(input logic [DATA_WIDTH-1:0] value,
                                      input logic fnd,
                                      input logic [CNT_W-1:0] cnt,
                                      input t_status st);
        t_rsp rsp;
        rsp.read_value  = 32'(value);
        rsp.found       = fnd;
        rsp.entry_count = 5'(cnt);
        rsp.status      = st;
        return rsp;
    endfunction

    oal_ram u_ram (
        .i_clk   (i_clk),
        .i_ram   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign pos_ins  = (32'(i_req.position) > 32'(r_count)) ? r_count
                                                           : CNT_W'(i_req.position);
    assign pos_last = r_count - 1'b1;
    assign pos_rd   = (32'(i_req.position) > 32'(pos_last)) ? pos_last
                                                            : CNT_W'(i_req.position);
    assign cur_dec  = r_cur - 1'b1;
    assign cur_inc  = r_cur + 1'b1;
    assign hit      = r_pend && (ram_rdata == r_word);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        OP_INSERT: if (!is_full)  n_state = S_SHIFT_UP;
                        OP_DELETE: if (!is_empty) n_state = S_SHIFT_DN;
                        OP_SEARCH: if (!is_empty) n_state = S_SEARCH;
                        OP_READ:   if (!is_empty) n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SHIFT_UP: begin
                if (r_cur <= r_pos) n_state = S_PLACE;
            end
            S_PLACE:    n_state = S_IDLE;
            S_SHIFT_DN: begin
                if (cur_inc >= r_count) n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (r_cur >= r_count) n_state = S_IDLE;
            end
            S_READ:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_cur   = r_cur;
        n_pos   = r_pos;
        n_wa    = r_wa;
        n_pend  = 1'b0;
        n_found = r_found;
        n_word  = r_word;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        ram_req.we    = 1'b0;
        ram_req.waddr = r_wa[IDX_W-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = pos_rd[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_word  = i_req.item_value[DATA_WIDTH-1:0];
                    n_found = 1'b0;
                    case (i_req.operation)
                        OP_INSERT: begin
                            if (is_full) begin
                                n_done = 1'b1;
                                n_rsp  = make_rsp('0, 1'b0, r_count, ST_FULL);
                            end else begin
                                n_pos = pos_ins;
                                n_cur = r_count;
                            end
                        end
                        OP_DELETE: begin
                            if (is_empty) begin
                                n_done = 1'b1;
                                n_rsp  = make_rsp('0, 1'b0, r_count, ST_EMPTY);
                            end else begin
                                n_pos = pos_rd;
                                n_cur = pos_rd;
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                n_done = 1'b1;
                                n_rsp  = make_rsp('0, 1'b0, r_count, ST_OK);
                            end else begin
                                n_cur = '0;
                            end
                        end
                        OP_READ: begin
                            if (is_empty) begin
                                n_done = 1'b1;
                                n_rsp  = make_rsp('0, 1'b0, r_count, ST_EMPTY);
                            end
                        end
                        default: n_done = 1'b0;
                    endcase
                end
            end
            S_SHIFT_UP: begin
                ram_req.we = r_pend;
                if (r_cur > r_pos) begin
                    ram_req.raddr = cur_dec[IDX_W-1:0];
                    n_pend        = 1'b1;
                    n_wa          = r_cur;
                    n_cur         = cur_dec;
                end
            end
            S_PLACE: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_pos[IDX_W-1:0];
                ram_req.wdata = r_word;
                n_count       = r_count + 1'b1;
                n_done        = 1'b1;
                n_rsp         = make_rsp('0, 1'b0, n_count, ST_OK);
            end
            S_SHIFT_DN: begin
                ram_req.we = r_pend;
                if (cur_inc < r_count) begin
                    ram_req.raddr = cur_inc[IDX_W-1:0];
                    n_pend        = 1'b1;
                    n_wa          = r_cur;
                    n_cur         = cur_inc;
                end else begin
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                    n_rsp   = make_rsp('0, 1'b0, n_count, ST_OK);
                end
            end
            S_SEARCH: begin
                n_found = r_found | hit;
                if (r_cur < r_count) begin
                    ram_req.raddr = r_cur[IDX_W-1:0];
                    n_pend        = 1'b1;
                    n_cur         = cur_inc;
                end else begin
                    n_done = 1'b1;
                    n_rsp  = make_rsp('0, n_found, r_count, ST_OK);
                end
            end
            S_READ: begin
                n_done = 1'b1;
                n_rsp  = make_rsp(ram_rdata, 1'b0, r_count, ST_OK);
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_pos   <= n_pos;
        r_wa    <= n_wa;
        r_found <= n_found;
        r_word  <= n_word;
        r_rsp   <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

/* src/oal_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered array list entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oal_ram (
    input  wire logic                          i_clk,
    input  wire oal_pkg::t_ram_req             i_ram,
    output logic [oal_pkg::DATA_WIDTH-1:0]     o_rdata
);
    import oal_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ram.we) begin
            r_mem[i_ram.waddr] <= i_ram.wdata;
        end
        r_rdata <= r_mem[i_ram.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/oal_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered array list checker
// Port-level assertions, bound to the ordered array list block.
// ----------------------------------------------------------------------------
module oal_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire logic          o_done,
    input  wire oal_pkg::t_rsp o_rsp
);
    import oal_pkg::*;

    // Every accepted transaction either keeps the block busy or reports at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted transaction neither busy nor reported");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result reported while busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status == ST_FULL |-> o_rsp.entry_count == 5'(CAPACITY))
        else $error("full status with list not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status == ST_EMPTY |->
            o_rsp.entry_count == '0 && o_rsp.read_value == '0 && !o_rsp.found)
        else $error("empty status with nonzero result");

    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.found |-> o_rsp.status == ST_OK && o_rsp.entry_count != '0)
        else $error("found reported on empty list or bad status");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire

/* verif/oal_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array list checker
// Watches the command and result channels of the list block. It keeps its own
// copy of the list, predicts each result when a transaction is taken, and
// compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module oal_list_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_busy,
    input  wire oal_pkg::t_req  i_req,
    input  wire logic           i_done,
    input  wire oal_pkg::t_rsp  i_rsp,
    output int                  o_error_count,
    output int                  o_pending
);
    import oal_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [DATA_WIDTH-1:0] list_mem [CAPACITY];
    int                    list_len;
    t_rsp                  results_due [$];
    int                    fail_cnt;

    initial begin
        foreach (list_mem[k]) list_mem[k] = '0;
        list_len      = 0;
        fail_cnt      = 0;
        o_error_count = 0;
        o_pending     = 0;
    end

    function automatic t_rsp apply_list_op(input t_req cmd);
        t_rsp                  rsp;
        logic [DATA_WIDTH-1:0] word;
        int                    p;
        int                    i;
        rsp        = '0;
        rsp.status = ST_OK;
        word       = cmd.item_value[DATA_WIDTH-1:0];
        p          = int'(cmd.position);
        case (cmd.operation)
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (p > list_len) p = list_len;
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = word;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    if (p > list_len - 1) p = list_len - 1;
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == word) rsp.found = 1'b1;
                end
            end
            default: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    if (p > list_len - 1) p = list_len - 1;
                    rsp.read_value = 32'(list_mem[p]);
                end
            end
        endcase
        rsp.entry_count = 5'(list_len);
        return rsp;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
        end else begin
            if (i_done) begin
                if (results_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: value=%h found=%0d count=%0d status=%0d",
                                 $time, i_rsp.read_value, i_rsp.found, i_rsp.entry_count,
                                 i_rsp.status);
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.read_value !== want.read_value || i_rsp.found !== want.found ||
                        i_rsp.entry_count !== want.entry_count ||
                        i_rsp.status !== want.status) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT)
                            $display({"[%0t] result mismatch: expected value=%h found=%0d ",
                                      "count=%0d status=%0d, got value=%h found=%0d ",
                                      "count=%0d status=%0d"},
                                     $time, want.read_value, want.found, want.entry_count,
                                     want.status, i_rsp.read_value, i_rsp.found,
                                     i_rsp.entry_count, i_rsp.status);
                    end
                end
            end
            if (i_start && !i_busy) results_due.push_back(apply_list_op(i_req));
        end
        o_error_count <= fail_cnt;
        o_pending     <= results_due.size();
    end

endmodule

/* verif/tb_ordered_array_list.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array list testbench
// Drives directed corner cases, then phases of random insert, delete, search
// and read transactions with random gaps that fill, drain and stir the list.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_ordered_array_list;
    import oal_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_CMDS  = 400;
    localparam int PHASE_LEN    = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        req;
    logic        busy;
    logic        done;
    t_rsp        rsp;
    int          error_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    logic [31:0] word_pool [8];
    bit          gaps_on = 1'b1;

    ordered_array_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_done  (done),
        .o_rsp   (rsp)
    );

    oal_list_checker list_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (req),
        .i_done        (done),
        .i_rsp         (rsp),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue_cmd(input t_op op, input logic [31:0] value,
                             input logic [7:0] pos, input int gap);
        if (gap > 0) begin
            start           = 1'b0;
            req.operation   = t_op'($urandom_range(0, 3));
            req.item_value  = $urandom;
            req.position    = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        start          = 1'b1;
        req.operation  = op;
        req.item_value = value;
        req.position   = pos;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    function automatic t_op pick_op(input t_phase phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  return r < 70 ? OP_INSERT : r < 80 ? OP_DELETE :
                             r < 90 ? OP_SEARCH : OP_READ;
            PH_DRAIN: return r < 15 ? OP_INSERT : r < 75 ? OP_DELETE :
                             r < 87 ? OP_SEARCH : OP_READ;
            default:  return t_op'(r % 4);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 1) == 1) return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_pos();
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(0, CAPACITY + 1));
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 1) ? 255 : 0);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int     n;
        t_phase phase;
        start   = 1'b0;
        req     = '0;
        i_rst_n = 1'b0;
        foreach (word_pool[k]) word_pool[k] = $urandom;
        word_pool[0] = 32'h0000_0000;
        word_pool[1] = 32'hFFFF_FFFF;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        issue_cmd(OP_READ,   32'h0000_0000, 8'd0,   0);
        issue_cmd(OP_DELETE, 32'h0000_0000, 8'd255, 0);
        issue_cmd(OP_SEARCH, 32'h0000_0000, 8'd0,   1);
        issue_cmd(OP_INSERT, 32'h0000_0000, 8'd0,   0);
        issue_cmd(OP_INSERT, 32'hFFFF_FFFF, 8'd255, 0);
        issue_cmd(OP_INSERT, 32'h5A5A_5A5A, 8'd0,   2);
        issue_cmd(OP_INSERT, 32'hA5A5_A5A5, 8'd1,   0);
        issue_cmd(OP_SEARCH, 32'hFFFF_FFFF, 8'd0,   0);
        issue_cmd(OP_SEARCH, 32'h0000_0000, 8'd255, 0);
        issue_cmd(OP_SEARCH, 32'hDEAD_BEEF, 8'd0,   0);
        issue_cmd(OP_READ,   32'hFFFF_FFFF, 8'd0,   0);
        issue_cmd(OP_READ,   32'h0000_0000, 8'd255, 3);
        issue_cmd(OP_READ,   32'h0000_0000, 8'd2,   0);
        issue_cmd(OP_DELETE, 32'h0000_0000, 8'd1,   0);
        issue_cmd(OP_DELETE, 32'h0000_0000, 8'd255, 0);
        issue_cmd(OP_DELETE, 32'h0000_0000, 8'd0,   0);
        issue_cmd(OP_DELETE, 32'h0000_0000, 8'd0,   1);
        issue_cmd(OP_DELETE, 32'hFFFF_FFFF, 8'd0,   0);
        issue_cmd(OP_READ,   32'h0000_0000, 8'd3,   0);

        n     = 0;
        phase = PH_FILL;
        while (n < RANDOM_CMDS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_LEN) begin
                issue_cmd(pick_op(phase), pick_word(), pick_pos(), pick_gap());
                n++;
            end
            phase = t_phase'($urandom_range(0, 2));
        end
        start = 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
